// File: hw/rtl/arpc_pkg.sv
// shared types and constants for the arp cache resolver
package arpc_pkg;

	// operation carried in the slave-side tuser
	typedef enum logic [1:0] {
		OP_LEARN   = 2'd0,
		OP_RESOLVE = 2'd1,
		OP_RECEIVE = 2'd2,
		OP_UNUSED  = 2'd3
	} arp_op_t;

	// configuration register indexes
	localparam logic CFG_OWN_IP      = 1'b0;
	localparam logic CFG_SUBNET_MASK = 1'b1;

	// header checks for a received packet
	localparam logic [15:0] MIN_PACKET_BYTES = 16'd28;
	localparam logic [15:0] HTYPE_ETHERNET   = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4       = 16'h0800;
	localparam logic [7:0]  HLEN_MAC         = 8'd6;
	localparam logic [7:0]  PLEN_IPV4        = 8'd4;
	localparam logic [15:0] OPER_REQUEST     = 16'd1;

	localparam logic [31:0] LIMITED_BCAST = 32'hFFFF_FFFF;
	localparam logic [47:0] MAC_ALL_ONES  = 48'hFFFF_FFFF_FFFF;

	localparam int IN_DATA_W  = 192;
	localparam int OUT_DATA_W = 88;

	// one table slot as stored in the memory
	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [47:0] mac;
	} arp_slot_t;

endpackage

// File: hw/rtl/arp_cache_resolver.sv
// arp cache resolver: ipv4-to-mac table in one memory, scanned per request
// learn, resolve and valid receive scan every slot after accept: one read per slot, the read data
//   registered and compared, then the result registered and a learn written back in ST_DONE
// broadcast resolve, dropped packet and unused op skip the scan and go straight to ST_DONE
// one request at a time: a new request is accepted only back in ST_IDLE, after the result is registered
// reset: after arst_n a clearing pass empties the table; no request is accepted until it ends
module arp_cache_resolver
	import arpc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// addr, hw_addr, target_addr, hw_type, proto_type, hw_len, proto_len,
	// arp_oper, packet_length
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [1:0]            s_axis_tuser,
	// result channel
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// resolved, is_broadcast, mac_out, send_request, send_reply,
	// target_ip_out, packet_dropped, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// configuration write port
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [31:0]           cfg_wdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	// configuration registers
	logic [31:0] own_ip_q;
	logic [31:0] subnet_mask_q;

	// request fields unpacked
	arp_op_t     in_op;
	logic [31:0] in_addr;
	logic [47:0] in_hw;
	logic [31:0] in_tpa;
	logic [15:0] in_htype;
	logic [15:0] in_ptype;
	logic [7:0]  in_hlen;
	logic [7:0]  in_plen;
	logic [15:0] in_oper;
	logic [15:0] in_plength;

	// request held during the scan
	arp_op_t     op_q;
	logic [31:0] addr_q;
	logic [47:0] hw_q;
	logic        bcast_q;
	logic        drop_q;
	logic        reply_q;
	logic        learn_q;

	// scan results
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [47:0]      hit_mac_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// table memory and its ports
	arp_slot_t        mem [ENTRIES];
	logic [CNT_W-1:0] scan_cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	arp_slot_t        rd_data_s1;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	arp_slot_t        wr_data;

	// clearing pass after reset
	logic             clr_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic in_fire;
	logic out_free;
	logic in_bcast;
	logic in_drop;
	logic scan_issue;
	logic [IDX_W-1:0] learn_idx;

	// result fields
	logic        r_resolved;
	logic        r_is_bcast;
	logic [47:0] r_mac;
	logic        r_send_req;
	logic        r_send_reply;
	logic [31:0] r_target;
	logic        r_dropped;

	assign in_op      = arp_op_t'(s_axis_tuser);
	assign in_addr    = s_axis_tdata[31:0];
	assign in_hw      = s_axis_tdata[79:32];
	assign in_tpa     = s_axis_tdata[111:80];
	assign in_htype   = s_axis_tdata[127:112];
	assign in_ptype   = s_axis_tdata[143:128];
	assign in_hlen    = s_axis_tdata[151:144];
	assign in_plen    = s_axis_tdata[159:152];
	assign in_oper    = s_axis_tdata[175:160];
	assign in_plength = s_axis_tdata[191:176];

	assign s_axis_tready = (state_q == ST_IDLE) && !clr_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// limited broadcast, or own network with all host bits set
	assign in_bcast = (in_addr == LIMITED_BCAST) ||
		(((in_addr & subnet_mask_q) == (own_ip_q & subnet_mask_q)) &&
		 ((in_addr & ~subnet_mask_q) == ~subnet_mask_q));

	assign in_drop = (in_plength < MIN_PACKET_BYTES) || (in_htype != HTYPE_ETHERNET) ||
		(in_ptype != PTYPE_IPV4) || (in_hlen != HLEN_MAC) || (in_plen != PLEN_IPV4);

	assign scan_issue = (state_q == ST_SCAN) && (scan_cnt_q != CNT_END);

	// update the matching slot, else the first free one, else slot 0
	assign learn_idx = hit_q ? hit_idx_q : (free_q ? free_idx_q : '0);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q      <= '0;
			subnet_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OWN_IP:      own_ip_q      <= cfg_wdata;
				CFG_SUBNET_MASK: subnet_mask_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// memory write: clearing pass or learn write-back
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_idx_q;
		wr_data = '0;
		if (clr_q) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_DONE) && out_free && learn_q) begin
			wr_en   = 1'b1;
			wr_addr = learn_idx;
			wr_data = '{valid: 1'b1, ip: addr_q, mac: hw_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[scan_cnt_q[IDX_W-1:0]];
		rd_idx_s1  <= scan_cnt_q[IDX_W-1:0];
	end

	// clearing pass sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	// request registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= in_op;
			addr_q  <= in_addr;
			hw_q    <= in_hw;
			bcast_q <= in_bcast;
			drop_q  <= in_drop;
			reply_q <= (in_oper == OPER_REQUEST) && (in_tpa == own_ip_q);
			learn_q <= (in_op == OP_LEARN) || ((in_op == OP_RECEIVE) && !in_drop);
		end
	end

	// sequencer and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			// lowest valid match and lowest free slot
			if (rd_vld_s1) begin
				if (rd_data_s1.valid && (rd_data_s1.ip == addr_q) && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_s1;
				end
				if (!rd_data_s1.valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						scan_cnt_q <= '0;
						case (in_op)
							OP_LEARN:   state_q <= ST_SCAN;
							OP_RESOLVE: state_q <= in_bcast ? ST_DONE : ST_SCAN;
							OP_RECEIVE: state_q <= in_drop ? ST_DONE : ST_SCAN;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					// last slot is evaluated in this cycle
					if (rd_vld_s1 && (rd_idx_s1 == IDX_LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_data_s1.valid && (rd_data_s1.ip == addr_q) && !hit_q) begin
			hit_mac_q <= rd_data_s1.mac;
		end
	end

	// result fields
	always_comb begin
		r_resolved   = 1'b0;
		r_is_bcast   = 1'b0;
		r_mac        = '0;
		r_send_req   = 1'b0;
		r_send_reply = 1'b0;
		r_target     = '0;
		r_dropped    = 1'b0;
		case (op_q)
			OP_RESOLVE: begin
				if (bcast_q) begin
					r_resolved = 1'b1;
					r_is_bcast = 1'b1;
					r_mac      = MAC_ALL_ONES;
				end else if (hit_q) begin
					r_resolved = 1'b1;
					r_mac      = hit_mac_q;
				end else begin
					r_send_req = 1'b1;
					r_target   = addr_q;
				end
			end
			OP_RECEIVE: begin
				if (drop_q) begin
					r_dropped = 1'b1;
				end else if (reply_q) begin
					r_send_reply = 1'b1;
					r_mac        = hw_q;
					r_target     = addr_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_axis_tdata <= {3'b000, r_dropped, r_target, r_send_reply, r_send_req,
				r_mac, r_is_bcast, r_resolved};
		end
	end

endmodule
